// File: hdl/iaid_pkg.sv
// Shared types, codes and constants of the indexed insert/delete store.
`timescale 1ns / 1ps

package iaid_pkg;

  // Fill count and capacity register width, fixed by the interface.
  localparam int unsigned CntW = 5;
  // Position field width.
  localparam int unsigned PosW = 4;
  // Data word width.
  localparam int unsigned WordW = 32;
  // Default number of cells.
  localparam int unsigned DepthDefault = 16;
  // Capacity register value after reset.
  localparam logic [CntW-1:0] CapResetVal = 5'd16;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [PosW-1:0]    position;
    logic signed [WordW-1:0] value;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic signed [WordW-1:0] read_value;
    logic [CntW-1:0]    fill_count;
  } rsp_t;

  // Broadcast to every cell in the chain for one accepted word.
  typedef struct packed {
    logic            ins;  // insert at pos, cells from pos up to cnt shift up
    logic            del;  // delete at pos, cells from pos below cnt-1 shift down
    logic [CntW-1:0] pos;
    logic [CntW-1:0] cnt;  // fill count before this word
  } cell_op_t;

endpackage

// File: hdl/iaid_cell.sv
// One storage cell of the insert/delete chain.
`timescale 1ns / 1ps

module iaid_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                            clk_i,
  input  iaid_pkg::cell_op_t              op_i,
  input  logic signed [iaid_pkg::WordW-1:0] wr_data_i,
  input  logic signed [iaid_pkg::WordW-1:0] lower_data_i,
  input  logic signed [iaid_pkg::WordW-1:0] upper_data_i,
  output logic signed [iaid_pkg::WordW-1:0] data_o,
  output logic                            hit_o
);
  import iaid_pkg::*;

  localparam int unsigned IdxBits = ($clog2(Idx + 2) > CntW) ? $clog2(Idx + 2) : CntW;
  localparam logic [IdxBits-1:0] MyIdx = IdxBits'(Idx);

  logic [IdxBits-1:0] pos_w;
  logic [IdxBits-1:0] cnt_w;
  logic signed [WordW-1:0] data_q;
  logic signed [WordW-1:0] data_d;

  assign pos_w = IdxBits'(op_i.pos);
  assign cnt_w = IdxBits'(op_i.cnt);
  assign hit_o = (MyIdx == pos_w);

  always_comb begin
    data_d = data_q;
    if (op_i.ins) begin
      if (MyIdx == pos_w) begin
        data_d = wr_data_i;
      end else if (MyIdx > pos_w && MyIdx <= cnt_w) begin
        data_d = lower_data_i;
      end
    end else if (op_i.del) begin
      if (MyIdx >= pos_w && (MyIdx + 1'b1) < cnt_w) begin
        data_d = upper_data_i;
      end
    end
  end

  // Payload only: never read before it is written below the fill count.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// File: hdl/indexed_array_insert_delete.sv
`timescale 1ns / 1ps
// Indexed insert/delete store: an ordered list of signed 32-bit words.
//
// Usage: a request word (cmd, position, value) on req_i is taken at a rising
// clock edge where start is high and busy is low. busy never rises: the chain
// of cells finishes every request in the edge that accepts it, so a new
// request can be issued every cycle. The answer word (status, read value and
// fill count after the request) appears on rsp_o in the following cycle, marked by
// done_o for exactly one cycle. There is no backpressure on the answer side;
// the receiver must take the word in that cycle.
// Throughput is one request per cycle; the figure is set by the single shift
// step that every cell takes in parallel, each cell comparing its own index
// with the position and the fill count.
// The capacity register is written on the cfg channel (cfg_valid_i and
// cfg_ready_o, data on cfg_data_i); cfg_ready_o is always high. Writes are
// meant to happen between requests.
// Reset clears the fill count, the answer strobe and sets the capacity to 16.
// Cell contents are not cleared; only cells below the fill count are read.
module indexed_array_insert_delete #(
  parameter int unsigned DEPTH = iaid_pkg::DepthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  iaid_pkg::req_t              req_i,
  output logic                        done_o,
  output iaid_pkg::rsp_t              rsp_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [iaid_pkg::CntW-1:0]   cfg_data_i
);
  import iaid_pkg::*;

  // The capacity register saturates the usable depth at its largest code.
  localparam logic [CntW-1:0] DepthCap =
      (DEPTH > 31) ? {CntW{1'b1}} : CntW'(DEPTH);

  logic [CntW-1:0] cap_q;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_d;
  logic [CntW-1:0] eff_cap;
  logic [CntW-1:0] pos_ext;
  logic            accept;
  logic            done_q;
  rsp_t            rsp_q;
  rsp_t            rsp_d;
  cell_op_t        op;
  logic signed [WordW-1:0] cell_data [DEPTH];
  logic                    cell_hit  [DEPTH];
  logic signed [WordW-1:0] rd_data;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign eff_cap     = (cap_q < DepthCap) ? cap_q : DepthCap;
  assign pos_ext     = CntW'(req_i.position);

  // Capacity register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapResetVal;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_data_i;
    end
  end

  // Read path: the one cell whose index matches the position drives the data.
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < int'(DEPTH); i++) begin
      if (cell_hit[i]) begin
        rd_data = rd_data | cell_data[i];
      end
    end
  end

  // Decode the request into a status, the new fill count and the cell command.
  always_comb begin
    op              = '0;
    op.cnt          = count_q;
    op.pos          = pos_ext;
    count_d         = count_q;
    rsp_d.status    = ST_OK;
    rsp_d.read_value = '0;
    case (req_i.cmd)
      CMD_INSERT, CMD_APPEND: begin
        if (count_q >= eff_cap) begin
          rsp_d.status = ST_FULL;
        end else begin
          if (req_i.cmd == CMD_APPEND) begin
            op.pos = count_q;
          end
          if (op.pos > count_q) begin
            rsp_d.status = ST_BADPOS;
          end else begin
            op.ins  = accept;
            count_d = count_q + 1'b1;
          end
        end
      end
      CMD_DELETE, CMD_READ: begin
        if (count_q == '0) begin
          rsp_d.status = ST_EMPTY;
        end else if (pos_ext >= count_q) begin
          rsp_d.status = ST_BADPOS;
        end else if (req_i.cmd == CMD_DELETE) begin
          op.del  = accept;
          count_d = count_q - 1'b1;
        end else begin
          rsp_d.read_value = rd_data;
        end
      end
      default: begin
        rsp_d.status = ST_OK;
      end
    endcase
    rsp_d.fill_count = count_d;
  end

  // The chain: each cell sees its two neighbors and the broadcast command.
  for (genvar g = 0; g < int'(DEPTH); g++) begin : g_cell
    logic signed [WordW-1:0] lower;
    logic signed [WordW-1:0] upper;
    if (g == 0) begin : g_first
      assign lower = req_i.value;
    end else begin : g_mid_lo
      assign lower = cell_data[g-1];
    end
    if (g == int'(DEPTH) - 1) begin : g_last
      assign upper = cell_data[g];
    end else begin : g_mid_hi
      assign upper = cell_data[g+1];
    end
    iaid_cell #(
      .Idx(g)
    ) u_cell (
      .clk_i        (clk_i),
      .op_i         (op),
      .wr_data_i    (req_i.value),
      .lower_data_i (lower),
      .upper_data_i (upper),
      .data_o       (cell_data[g]),
      .hit_o        (cell_hit[g])
    );
  end

  // Fill count and answer strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // Answer word, valid while done_o is high.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // Every accepted request is answered in the next cycle, and only then.
  a_done_follows_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
      done_o == $past(accept))
    else $error("answer strobe does not follow an accepted request");

  // The fill count never exceeds the usable depth.
  a_count_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
      count_q <= DepthCap)
    else $error("fill count beyond the usable depth");

  // A refused request leaves the fill count unchanged.
  a_refused_keeps_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
      (done_o && rsp_o.status != ST_OK) |-> (rsp_o.fill_count == $past(count_q)))
    else $error("refused request changed the fill count");

  // Read data is nonzero only on a successful request.
  a_read_only_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
      (done_o && rsp_o.read_value != '0) |-> (rsp_o.status == ST_OK))
    else $error("read data on a refused request");

endmodule

// File: bench/iaid_checker.sv
// Scoreboard of the indexed insert/delete store: watches the channels, predicts, compares.
`timescale 1ns / 1ps

module iaid_checker (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    busy_i,
  input  iaid_pkg::req_t          req_i,
  input  logic                    done_i,
  input  iaid_pkg::rsp_t          rsp_i,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [iaid_pkg::CntW-1:0] cfg_data_i,
  output int unsigned             fail_count_o,
  output int unsigned             pending_o,
  output logic [iaid_pkg::CntW-1:0] fill_o
);
  import iaid_pkg::*;

  localparam int unsigned Depth = DepthDefault;

  // Shadow copy of the store.
  logic signed [WordW-1:0] cells [Depth];
  logic [CntW-1:0]         fill;
  logic [CntW-1:0]         capacity;

  rsp_t        answers_due [$];
  rsp_t        want;
  int unsigned errors;

  // Applies one request to the shadow store and returns the answer it must produce.
  function automatic rsp_t apply_request(req_t r);
    rsp_t        a;
    int unsigned lim;
    int unsigned p;
    a.status     = ST_OK;
    a.read_value = '0;
    lim = (capacity < Depth) ? capacity : Depth;
    p   = r.position;
    if (r.cmd == CMD_INSERT || r.cmd == CMD_APPEND) begin
      if (fill >= lim) begin
        a.status = ST_FULL;
      end else begin
        if (r.cmd == CMD_APPEND) begin
          p = fill;
        end
        if (p > fill) begin
          a.status = ST_BADPOS;
        end else begin
          for (int i = fill; i > p; i--) begin
            cells[i] = cells[i-1];
          end
          cells[p] = r.value;
          fill = fill + 1'b1;
        end
      end
    end else if (fill == 0) begin
      a.status = ST_EMPTY;
    end else if (p >= fill) begin
      a.status = ST_BADPOS;
    end else if (r.cmd == CMD_DELETE) begin
      for (int i = p; i + 1 < fill; i++) begin
        cells[i] = cells[i+1];
      end
      fill = fill - 1'b1;
    end else begin
      a.read_value = cells[p];
    end
    a.fill_count = fill;
    return a;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      answers_due.delete();
      fill         = '0;
      capacity     = CapResetVal;
      errors       = 0;
      pending_o    <= 0;
      fill_o       <= '0;
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        capacity = cfg_data_i;
      end
      // The answer to a word accepted here shows up in the next cycle, so pushing
      // first never lets a same-edge answer be paired with the wrong word.
      if (start_i && !busy_i) begin
        answers_due.push_back(apply_request(req_i));
      end
      if (done_i) begin
        if (answers_due.size() == 0) begin
          $error("answer word with no request outstanding");
          errors += 1;
        end else begin
          want = answers_due.pop_front();
          if (rsp_i.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, rsp_i.status);
            errors += 1;
          end
          if (rsp_i.read_value !== want.read_value) begin
            $error("read_value mismatch: expected %0d, actual %0d",
                   want.read_value, rsp_i.read_value);
            errors += 1;
          end
          if (rsp_i.fill_count !== want.fill_count) begin
            $error("fill_count mismatch: expected %0d, actual %0d",
                   want.fill_count, rsp_i.fill_count);
            errors += 1;
          end
        end
      end
      pending_o    <= answers_due.size();
      fill_o       <= fill;
      fail_count_o <= errors;
    end
  end

endmodule

// File: bench/indexed_array_insert_delete_tb.sv
// Stimulus and verdict for the indexed insert/delete store.
`timescale 1ns / 1ps

module indexed_array_insert_delete_tb;
  import iaid_pkg::*;

  // A stretch this long with no word moving on any channel means the block hung.
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned NumPhases = 9;
  localparam int unsigned WordsPerPhase = 103;

  logic            clk_i;
  logic            rst_ni = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  req_t            req_i = '0;
  logic            done_o;
  rsp_t            rsp_o;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [CntW-1:0] cfg_data_i = '0;

  int unsigned     fail_count;
  int unsigned     pending;
  logic [CntW-1:0] model_fill;
  int unsigned     stall_cycles = 0;
  logic [CntW-1:0] phase_caps [NumPhases];

  indexed_array_insert_delete dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  iaid_checker scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req_i),
    .done_i       (done_o),
    .rsp_i        (rsp_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .fill_o       (model_fill)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Watchdog: any word moving on the request, answer or register channel
  // resets the count. Reset and the end-of-run drain are far shorter.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic req_t make_req(cmd_e c, int unsigned p, logic [WordW-1:0] v);
    req_t r;
    r.cmd      = c;
    r.position = PosW'(p);
    r.value    = v;
    return r;
  endfunction

  // Builds one random request. The mix leans toward filling or toward emptying
  // so that the count sweeps between empty and the capacity, and positions
  // mostly fall inside the stored range (with the count itself included, which
  // is a legal insert spot but a bad read or delete spot). One word in ten
  // uses a fully random position to hit the out-of-range checks. The fill
  // count seen here may lag by one word, which only blurs the aim a little.
  function automatic req_t pick_request(bit grow);
    req_t        r;
    int unsigned roll;
    int unsigned top_pos;
    roll    = $urandom_range(99);
    top_pos = (model_fill > 15) ? 15 : model_fill;
    if (grow) begin
      r.cmd = (roll < 40) ? CMD_INSERT : (roll < 65) ? CMD_APPEND :
              (roll < 80) ? CMD_DELETE : CMD_READ;
    end else begin
      r.cmd = (roll < 15) ? CMD_INSERT : (roll < 25) ? CMD_APPEND :
              (roll < 70) ? CMD_DELETE : CMD_READ;
    end
    if ($urandom_range(9) == 0) begin
      r.position = PosW'($urandom_range(15));
    end else begin
      r.position = PosW'($urandom_range(top_pos));
    end
    case ($urandom_range(15))
      0:       r.value = 32'h8000_0000;
      1:       r.value = 32'h7fff_ffff;
      2:       r.value = '0;
      3:       r.value = '1;
      default: r.value = $urandom();
    endcase
    return r;
  endfunction

  // Offers one request word and holds it until the block takes it. In each
  // cycle the line goes quiet with the given odds, so that share of cycles
  // stays idle. start is left high afterwards, so back-to-back words never
  // drop it.
  task automatic send_word(req_t r, int unsigned idle_pct);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
  endtask

  // Stops sending and waits until every answer word has come back. The first
  // edge is always taken so the count includes the last accepted word.
  task automatic wait_all_answered();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (2) @(posedge clk_i);
  endtask

  // Capacity writes only happen with the store idle.
  task automatic write_capacity(logic [CntW-1:0] cap);
    wait_all_answered();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned idle_pct;

    // Capacity schedule: above the depth, below the count left over from the previous phase, zero,
    // the exact depth, one, a random pick, half the depth, one above the depth, and the exact depth again.
    phase_caps[0] = 5'd31;
    phase_caps[1] = 5'd3;
    phase_caps[2] = 5'd0;
    phase_caps[3] = 5'd16;
    phase_caps[4] = 5'd1;
    phase_caps[5] = CntW'($urandom_range(31));
    phase_caps[6] = 5'd8;
    phase_caps[7] = 5'd17;
    phase_caps[8] = 5'd16;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words at the reset capacity of 16.
    // Reading and deleting an empty store, and an insert beyond the count.
    send_word(make_req(CMD_READ, 0, 32'h0), 0);
    send_word(make_req(CMD_DELETE, 5, 32'h0), 0);
    send_word(make_req(CMD_INSERT, 15, 32'h1234_5678), 0);
    // The first insert, then an append whose position field must be ignored.
    send_word(make_req(CMD_INSERT, 0, 32'h7fff_ffff), 0);
    send_word(make_req(CMD_APPEND, 9, 32'h8000_0000), 0);
    // Insert in the middle, then exactly at the count, then one past it.
    send_word(make_req(CMD_INSERT, 1, 32'hffff_ffff), 0);
    send_word(make_req(CMD_INSERT, 3, 32'h0), 0);
    send_word(make_req(CMD_INSERT, 5, 32'h5555_aaaa), 0);
    // Reads at both ends of the range, at the count, and at the top position.
    send_word(make_req(CMD_READ, 0, 32'h0), 0);
    send_word(make_req(CMD_READ, 3, 32'h0), 0);
    send_word(make_req(CMD_READ, 4, 32'h0), 0);
    send_word(make_req(CMD_READ, 15, 32'hffff_ffff), 0);
    // Deletes: out of range, in the middle, and the last entry.
    send_word(make_req(CMD_DELETE, 4, 32'h0), 0);
    send_word(make_req(CMD_DELETE, 1, 32'h0), 0);
    send_word(make_req(CMD_DELETE, 2, 32'h0), 0);
    send_word(make_req(CMD_READ, 1, 32'h0), 0);
    send_word(make_req(CMD_READ, 0, 32'h0), 0);

    // Random phases. The sender idles 22 percent of the time for the first
    // three, 48 percent for the next three, and never for the last three.
    // Halfway through each phase the sender also waits out every answer.
    for (int ph = 0; ph < NumPhases; ph++) begin
      write_capacity(phase_caps[ph]);
      idle_pct = (ph < 3) ? 22 : (ph < 6) ? 48 : 0;
      for (int n = 0; n < WordsPerPhase; n++) begin
        if (n == WordsPerPhase / 2) begin
          wait_all_answered();
        end
        send_word(pick_request(((n / 35) % 2) == 0), idle_pct);
      end
    end

    wait_all_answered();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/iaid_pkg.sv
hdl/iaid_cell.sv
hdl/indexed_array_insert_delete.sv
bench/iaid_checker.sv
bench/indexed_array_insert_delete_tb.sv
